[sv/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Item kinds, control characters, register indexes and field widths.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CELL_W   = 16;
    localparam int COLOR_W  = 4;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 7;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOREGROUND = 1'b0,
        CFG_BACKGROUND = 1'b1
    } cfg_index_t;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd2;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

endpackage

[sv/tcw_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw interfaces: command, response and register write channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface tcw_cmd_if
    import tcw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  character;
    logic [INDEX_W-1:0] cell_index;

    modport source (output valid, kind, character, cell_index, input ready);
    modport sink   (input valid, kind, character, cell_index, output ready);
endinterface

interface tcw_rsp_if
    import tcw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_column;

    modport source (output valid, cell_value, cursor_row, cursor_column, input ready);
    modport sink   (input valid, cell_value, cursor_row, cursor_column, output ready);
endinterface

interface tcw_cfg_if
    import tcw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/text_console_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine with cursor and scroll
// Path to rsp.valid: a put of a plain character, newline or return goes
//   via S_DONE; a read via S_RD, S_RD_CAP, S_DONE; a clear via S_FILL over
//   all cells; a scrolling put copies rows up, then blanks the bottom row.
// Flow: one transaction in work; cmd.ready is high only while idle, so a
//   new command waits; a stalled response holds the next one in S_DONE.
// Reset: cursor to 0,0, colors to 2/0, then a clearing pass zeroes the
//   screen before the first command is taken.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic     clk,
    input  logic     rst_n,
    tcw_cmd_if.sink  cmd,
    tcw_rsp_if.source rsp,
    tcw_cfg_if.sink  cfg
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [AW-1:0]    LAST_ADDR   = AW'(CELLS - 1);
    localparam logic [AW-1:0]    BOTTOM_ADDR = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]    ROW_STRIDE  = AW'(COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);

    // Sequencer states. FILL is shared by the reset pass, the clear command
    // and the blank bottom row after a scroll.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_SCR_RD,
        S_SCR_WR,
        S_RD,
        S_RD_CAP,
        S_DONE
    } state_t;

    state_t state_reg;

    // Screen memory: one write port, one registered read port.
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    logic [AW-1:0]     addr_reg;      // sweep pointer / read address
    logic [CELL_W-1:0] fill_data_reg;
    logic              report_reg;    // fill ends in a response (not the reset pass)

    // Cursor, kept also as a linear cell address to avoid a multiply.
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [AW-1:0]     cur_addr_reg;

    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [7:0]         attr;

    logic [CELL_W-1:0] cell_reg;

    logic                 rsp_valid_reg;
    logic [CELL_W-1:0]    rsp_cell_reg;
    logic [OUT_ROW_W-1:0] rsp_row_reg;
    logic [OUT_COL_W-1:0] rsp_col_reg;

    logic              cmd_fire;
    kind_t             cmd_kind;
    logic              is_newline;
    logic              is_return;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;

    assign attr       = {bg_reg, fg_reg};
    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign cmd_kind   = kind_t'(cmd.kind);
    assign is_newline = (cmd.character == CH_NEWLINE);
    assign is_return  = (cmd.character == CH_RETURN);

    assign cfg.ready  = 1'b1;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.cell_value    = rsp_cell_reg;
    assign rsp.cursor_row    = rsp_row_reg;
    assign rsp.cursor_column = rsp_col_reg;

    // Single write port: printed character, scroll copy, or fill sweep.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = fill_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_we    = cmd_fire && (cmd_kind == KIND_PUT) && !is_newline && !is_return;
                mem_waddr = cur_addr_reg;
                mem_wdata = {attr, cmd.character};
            end
            S_SCR_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg - ROW_STRIDE;
                mem_wdata = rd_data_reg;
            end
            S_FILL:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // Color registers; writes are taken in any state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_FOREGROUND: fg_reg <= cfg.data;
                CFG_BACKGROUND: bg_reg <= cfg.data;
                default:        fg_reg <= fg_reg;
            endcase
        end
    end

    // Sequencer with cursor and registered response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            addr_reg      <= '0;
            fill_data_reg <= '0;
            report_reg    <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_addr_reg  <= '0;
            cell_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_cell_reg  <= '0;
            rsp_row_reg   <= '0;
            rsp_col_reg   <= '0;
        end
        else
        begin
            // S_DONE either loads a new response or holds a stalled one
            if (rsp.ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        cell_reg  <= '0;
                        state_reg <= S_DONE;
                        unique case (cmd_kind)
                            KIND_PUT:
                            begin
                                if (is_return)
                                begin
                                    col_reg      <= '0;
                                    cur_addr_reg <= cur_addr_reg - AW'(col_reg);
                                end
                                else if (is_newline || col_reg == LAST_COL)
                                begin
                                    col_reg <= '0;
                                    if (row_reg == LAST_ROW)
                                    begin
                                        // past the last row: scroll up
                                        row_reg      <= LAST_ROW;
                                        cur_addr_reg <= BOTTOM_ADDR;
                                        addr_reg     <= ROW_STRIDE;
                                        state_reg    <= S_SCR_RD;
                                    end
                                    else
                                    begin
                                        row_reg      <= row_reg + 1'b1;
                                        cur_addr_reg <= cur_addr_reg - AW'(col_reg)
                                                        + ROW_STRIDE;
                                    end
                                end
                                else
                                begin
                                    col_reg      <= col_reg + 1'b1;
                                    cur_addr_reg <= cur_addr_reg + 1'b1;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                addr_reg      <= '0;
                                fill_data_reg <= {attr, 8'h00};
                                report_reg    <= 1'b1;
                                state_reg     <= S_FILL;
                            end
                            KIND_READ:
                            begin
                                if (32'(cmd.cell_index) < CELLS)
                                begin
                                    addr_reg  <= AW'(cmd.cell_index);
                                    state_reg <= S_RD;
                                end
                            end
                            KIND_NONE:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCR_RD:
                begin
                    state_reg <= S_SCR_WR;
                end
                S_SCR_WR:
                begin
                    if (addr_reg == LAST_ADDR)
                    begin
                        addr_reg      <= BOTTOM_ADDR;
                        fill_data_reg <= {attr, CH_BLANK};
                        report_reg    <= 1'b1;
                        state_reg     <= S_FILL;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= S_SCR_RD;
                    end
                end
                S_FILL:
                begin
                    if (addr_reg == LAST_ADDR)
                    begin
                        state_reg <= report_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_RD_CAP;
                end
                S_RD_CAP:
                begin
                    cell_reg  <= rd_data_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_cell_reg  <= cell_reg;
                        rsp_row_reg   <= OUT_ROW_W'(row_reg);
                        rsp_col_reg   <= OUT_COL_W'(col_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/tcw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Tracks outstanding transactions; checks hold, pending count, cursor range.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cmd_valid,
    input logic                 cmd_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [CELL_W-1:0]    rsp_cell_value,
    input logic [OUT_ROW_W-1:0] rsp_cursor_row,
    input logic [OUT_COL_W-1:0] rsp_cursor_column
);

    logic [1:0] pending_reg;
    logic       cmd_fire;
    logic       rsp_fire;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, cmd_fire} - {1'b0, rsp_fire};
        end
    end

    // A stalled response holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_value)
            && $stable(rsp_cursor_row) && $stable(rsp_cursor_column))
        else $error("response changed while stalled");

    // Every response belongs to an accepted command.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("response without a pending command");

    // At most one finished result waits while one more command is in work.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |-> pending_reg < 2'd2)
        else $error("command taken with two outstanding");

    // Cursor stays on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_cursor_row) < ROWS && 32'(rsp_cursor_column) < COLUMNS)
        else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
) u_tcw_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cmd_valid(cmd.valid),
    .cmd_ready(cmd.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_cell_value(rsp.cell_value),
    .rsp_cursor_row(rsp.cursor_row),
    .rsp_cursor_column(rsp.cursor_column)
);
